[rtl/awg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// awg_pkg
// Shared widths, register indexes, sideband type and the elaboration-time
// sine table arithmetic for the waveform point generator.
// ---------------------------------------------------------------------------
package awg_pkg;

  localparam int unsigned IDX_W    = 12;   // point index width
  localparam int unsigned DAC_W    = 12;   // sample width
  localparam int unsigned CNT_W    = 13;   // point count width
  localparam int unsigned SIN_W    = 16;   // signed sine table entry width
  localparam int unsigned DAC_MAX  = 4095;
  localparam int unsigned DEF_MAX_POINTS = 4096;
  localparam int unsigned DEF_PHASE_BITS = 12;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SHAPE  = 2'd0,
    REG_AMP    = 2'd1,
    REG_OFFSET = 2'd2,
    REG_COUNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } shape_t;

  // control that travels alongside each transaction
  typedef struct packed {
    shape_t shape;
    logic   last;   // index is the final point of the period
    logic   low;    // index lies in the first half of the period
  } side_t;

  // (a * b + optional half) >> 60
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b,
                                          input logic rnd);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    if (rnd) begin
      prod = prod + (128'd1 << 59);
    end
    return prod[123:60];
  endfunction

  // round(32767 * sin(x)) for x in Q60, 0 <= x <= pi/2
  function automatic logic signed [SIN_W-1:0] sine_code(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    x2   = mul_q60(x, x, 1'b0);
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = mul_q60(term, x2, 1'b0) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    res = mul_q60(sum, 64'd32767, 1'b1);
    return SIN_W'(res);
  endfunction

endpackage
`default_nettype wire

[rtl/awg_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// awg_sine_rom
// Quarter-wave sine table, filled at elaboration, with a registered read.
// ---------------------------------------------------------------------------
module awg_sine_rom #(
  parameter int unsigned PHASE_BITS = awg_pkg::DEF_PHASE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [PHASE_BITS-2:0]            addr,
  output logic signed [awg_pkg::SIN_W-1:0]      data
);
  import awg_pkg::*;

  localparam int unsigned QUARTER = 1 << (PHASE_BITS - 2);
  localparam logic [63:0] STEP    = TWO_PI_Q60 >> PHASE_BITS;

  logic signed [SIN_W-1:0] rom [QUARTER+1];

  // build one constant entry per quarter-wave point
  for (genvar r = 0; r <= QUARTER; r++) begin : g_entry
    localparam logic signed [SIN_W-1:0] ENTRY = sine_code(STEP * 64'(r));
    assign rom[r] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule
`default_nettype wire

[rtl/awg_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// awg_divider
// Pipelined restoring divider: one quotient bit per stage, sideband and
// valid bits carried alongside, whole pipe held while en is low.
// ---------------------------------------------------------------------------
module awg_divider #(
  parameter int unsigned DW = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire logic [DW-1:0]                dividend,
  input  wire logic [awg_pkg::CNT_W-1:0]    divisor,
  input  wire awg_pkg::side_t               side_in,
  output logic                              out_vld,
  output logic [DW-1:0]                     quotient,
  output awg_pkg::side_t                    side_out
);
  import awg_pkg::*;

  logic               vld  [DW+1];
  logic [CNT_W-1:0]   rem  [DW+1];
  logic [DW-1:0]      work [DW+1];
  logic [CNT_W-1:0]   dvs  [DW+1];
  side_t              side [DW+1];

  // load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      work[0] <= dividend;
      dvs[0]  <= divisor;
      side[0] <= side_in;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [CNT_W:0] trial;
    logic           ge;

    assign trial = {rem[k-1], work[k-1][DW-1]};
    assign ge    = trial >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? CNT_W'(trial - {1'b0, dvs[k-1]}) : trial[CNT_W-1:0];
        work[k] <= {work[k-1][DW-2:0], ge};
        dvs[k]  <= dvs[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_vld  = vld[DW];
  assign quotient = work[DW];
  assign side_out = side[DW];

endmodule
`default_nettype wire

[rtl/waveform_point_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// waveform_point_generator
// Turns a point index into one 12-bit DAC sample of the configured shape.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, point_index           | in
//  output   | out_valid, out_ready, sample, last_point  | out
//  config   | psel, penable, pwrite, paddr, pwdata, ... | APB
//
//  One transaction enters per clock unless the output stalls. The restoring
//  divider forms most of the pipe (one quotient bit per stage, DW = max(12+PHASE_BITS, 25)).
//  rst clears all valid bits and loads the register reset values.
//  When the output register holds a transaction that is not taken, every
//  stage holds; in_ready falls in the same cycle.
// ---------------------------------------------------------------------------
module waveform_point_generator #(
  parameter int unsigned MAX_POINTS = awg_pkg::DEF_MAX_POINTS,
  parameter int unsigned PHASE_BITS = awg_pkg::DEF_PHASE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [awg_pkg::IDX_W-1:0]   point_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [awg_pkg::DAC_W-1:0]        sample,
  output logic                             last_point,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import awg_pkg::*;

  localparam int unsigned PW  = IDX_W + PHASE_BITS;
  localparam int unsigned DW  = (PW > 25) ? PW : 25;
  localparam int unsigned LW  = DW + 3;
  localparam int unsigned CW  = 17;

  // configuration registers
  shape_t             wave_shape;
  logic [DAC_W-1:0]   amplitude;
  logic [DAC_W-1:0]   offset;
  logic [CNT_W-1:0]   point_count;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape  <= SHAPE_SINE;
      amplitude   <= 12'd1024;
      offset      <= 12'd2048;
      point_count <= 13'd4096;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SHAPE:  wave_shape  <= shape_t'(pwdata[1:0]);
        REG_AMP:    amplitude   <= pwdata[DAC_W-1:0];
        REG_OFFSET: offset      <= pwdata[DAC_W-1:0];
        REG_COUNT:  point_count <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SHAPE:  prdata = {30'd0, wave_shape};
      REG_AMP:    prdata = {20'd0, amplitude};
      REG_OFFSET: prdata = {20'd0, offset};
      REG_COUNT:  prdata = {19'd0, point_count};
      default:    prdata = '0;
    endcase
  end

  // global advance: every stage moves unless the output is stalled
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: clamp the period, flag last and first-half points
  logic [CNT_W-1:0] n_clamp;
  logic [CNT_W-1:0] half_c;

  always_comb begin
    if (point_count < CNT_W'(2)) begin
      n_clamp = CNT_W'(2);
    end else if (CW'(point_count) > CW'(MAX_POINTS)) begin
      n_clamp = CNT_W'(MAX_POINTS);
    end else begin
      n_clamp = point_count;
    end
    half_c = n_clamp >> 1;
  end

  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [CNT_W-1:0] s1_n;
  logic [CNT_W-1:0] s1_half;
  side_t            s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx        <= point_index;
      s1_n          <= n_clamp;
      s1_half       <= half_c;
      s1_side.shape <= wave_shape;
      s1_side.last  <= CNT_W'(point_index) == n_clamp - CNT_W'(1);
      s1_side.low   <= CNT_W'(point_index) < half_c;
    end
  end

  // stage 2: form dividend and divisor for the chosen shape
  logic [IDX_W-1:0]         tri_idx;
  logic [2*DAC_W:0]         ramp_num;
  logic [DW-1:0]            div_num;
  logic [CNT_W-1:0]         div_den;

  always_comb begin
    tri_idx = (s1_side.shape == SHAPE_TRIANGLE && !s1_side.low)
            ? IDX_W'(CNT_W'(s1_idx) - s1_half) : s1_idx;
    ramp_num = {(2*DAC_W)'(amplitude) * (2*DAC_W)'(tri_idx), 1'b0};
    unique case (s1_side.shape)
      SHAPE_SINE: begin
        div_num = DW'({s1_idx, PHASE_BITS'(0)});
        div_den = s1_n;
      end
      SHAPE_TRIANGLE: begin
        div_num = DW'(ramp_num);
        div_den = s1_half;
      end
      default: begin
        div_num = DW'(ramp_num);
        div_den = s1_n;
      end
    endcase
  end

  logic             dv_valid;
  logic [DW-1:0]    dv_quo;
  side_t            dv_side;

  awg_divider #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s1_valid),
    .dividend (div_num),
    .divisor  (div_den),
    .side_in  (s1_side),
    .out_vld  (dv_valid),
    .quotient (dv_quo),
    .side_out (dv_side)
  );

  // tail stage 1: fold the phase into a quarter-wave table address
  logic [1:0]            quad;
  logic [PHASE_BITS-3:0] q_off;
  logic [PHASE_BITS-2:0] rom_addr;
  logic signed [SIN_W-1:0] rom_data;

  assign quad     = dv_quo[PHASE_BITS-1 -: 2];
  assign q_off    = dv_quo[PHASE_BITS-3:0];
  assign rom_addr = quad[0] ? ((PHASE_BITS-1)'(1) << (PHASE_BITS - 2)) - (PHASE_BITS-1)'(q_off)
                            : (PHASE_BITS-1)'(q_off);

  awg_sine_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .data (rom_data)
  );

  logic          t1_valid;
  logic [DW-1:0] t1_quo;
  logic          t1_neg;
  side_t         t1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (adv) begin
      t1_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_quo  <= dv_quo;
      t1_neg  <= quad[1];
      t1_side <= dv_side;
    end
  end

  // tail stage 2: scale the sine, build the linear shapes
  logic signed [SIN_W-1:0]     sin_val;
  logic signed [DAC_W+SIN_W:0] prod_c;
  logic signed [LW-1:0]        amp_s;
  logic signed [LW-1:0]        off_s;
  logic signed [LW-1:0]        quo_s;
  logic signed [LW-1:0]        lin_c;

  always_comb begin
    sin_val = t1_neg ? -rom_data : rom_data;
    prod_c  = $signed({1'b0, amplitude}) * sin_val;
    amp_s   = $signed(LW'(amplitude));
    off_s   = $signed(LW'(offset));
    quo_s   = $signed(LW'(t1_quo));
    unique case (t1_side.shape)
      SHAPE_SQUARE:   lin_c = t1_side.low ? off_s + amp_s : off_s - amp_s;
      SHAPE_TRIANGLE: lin_c = t1_side.low ? off_s - amp_s + quo_s : off_s + amp_s - quo_s;
      default:        lin_c = off_s - amp_s + quo_s;
    endcase
  end

  logic                        t2_valid;
  logic signed [DAC_W+SIN_W:0] t2_prod;
  logic signed [LW-1:0]        t2_lin;
  side_t                       t2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (adv) begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_prod <= prod_c;
      t2_lin  <= lin_c;
      t2_side <= t1_side;
    end
  end

  // output stage: floor-shift the sine, pick the shape, saturate
  logic signed [LW-1:0] sine_v;
  logic signed [LW-1:0] pick_v;
  logic [DAC_W-1:0]     sat_v;

  always_comb begin
    sine_v = $signed(LW'(offset)) + LW'(t2_prod >>> 15);
    pick_v = (t2_side.shape == SHAPE_SINE) ? sine_v : t2_lin;
    if (pick_v < 0) begin
      sat_v = '0;
    end else if (pick_v > $signed(LW'(DAC_MAX))) begin
      sat_v = DAC_W'(DAC_MAX);
    end else begin
      sat_v = pick_v[DAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample     <= sat_v;
      last_point <= t2_side.last;
    end
  end

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input held without an output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample) && $stable(last_point)))
    else $error("stalled output changed");
  a_amp_wr: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[3:2] == REG_AMP) |=> amplitude == $past(pwdata[DAC_W-1:0]))
    else $error("amplitude write lost");

endmodule
`default_nettype wire
